// ===== hdl/detection_box_class_filter_unit_macros.svh =====
// Assertion macros for the detection box class filter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef DETECTION_BOX_CLASS_FILTER_UNIT_MACROS_SVH
`define DETECTION_BOX_CLASS_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DBCF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DBCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dbcf_pkg.sv =====
// Shared types and constants for the detection box class filter.
// No dependencies.
`timescale 1ns / 1ps

package dbcf_pkg;

  localparam int COORD_W = 12;
  localparam int FRAC_W  = 16;
  localparam int SCALE_W = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_SCALE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_RATIO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BALL_RATIO_HIGH = 3'd4;

  // Register reset values
  localparam logic [COORD_W-1:0] RST_FRAME_WIDTH     = 12'd640;
  localparam logic [COORD_W-1:0] RST_FRAME_HEIGHT    = 12'd480;
  localparam logic [SCALE_W-1:0] RST_BALL_SCALE      = 9'd128;
  localparam logic [COORD_W-1:0] RST_BALL_RATIO_LOW  = 12'd192;
  localparam logic [COORD_W-1:0] RST_BALL_RATIO_HIGH = 12'd320;

  // Class labels
  localparam logic [7:0] LABEL_BALL     = 8'd0;
  localparam logic [7:0] LABEL_GOAL     = 8'd1;
  localparam logic [7:0] LABEL_OBSTACLE = 8'd2;

  // Verdict codes
  localparam logic [1:0] VERDICT_REJECT   = 2'd0;
  localparam logic [1:0] VERDICT_BALL     = 2'd1;
  localparam logic [1:0] VERDICT_GOAL     = 2'd2;
  localparam logic [1:0] VERDICT_OBSTACLE = 2'd3;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;      // capture the request
    logic step_lo;   // left and top corners
    logic step_hi;   // right and bottom corners
    logic step_dim;  // box size and frame scale products
    logic step_fin;  // ratio products, verdict, result register
  } dbcf_cmd_t;

endpackage

// ===== hdl/dbcf_ctrl.sv =====
// Sequencer for the detection box class filter: one request at a time.
// Depends on dbcf_pkg.
`timescale 1ns / 1ps

module dbcf_ctrl
  import dbcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output dbcf_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LO   = 5'b00010,
    S_HI   = 5'b00100,
    S_DIM  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_go;

  assign in_ready = (state_r == S_IDLE);
  // finish only when the result register is free or being emptied
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.load     = in_valid && in_ready;
    cmd.step_lo  = (state_r == S_LO);
    cmd.step_hi  = (state_r == S_HI);
    cmd.step_dim = (state_r == S_DIM);
    cmd.step_fin = fin_go;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LO;
      end
      S_LO:  state_nxt = S_HI;
      S_HI:  state_nxt = S_DIM;
      S_DIM: state_nxt = S_FIN;
      S_FIN: begin
        if (fin_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/dbcf_dp.sv =====
// Datapath for the detection box class filter: config registers, two shared
// multipliers, corner clamps, class maxima and the result register. Uses dbcf_pkg.
`timescale 1ns / 1ps

module dbcf_dp
  import dbcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dbcf_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_first_in_frame,
  input  logic [7:0]            in_class_label,
  input  logic [FRAC_W-1:0]     in_confidence,
  input  logic [FRAC_W-1:0]     in_center_x,
  input  logic [FRAC_W-1:0]     in_center_y,
  input  logic [FRAC_W-1:0]     in_box_w,
  input  logic [FRAC_W-1:0]     in_box_h,
  output logic [COORD_W-1:0]    out_left_px,
  output logic [COORD_W-1:0]    out_top_px,
  output logic [COORD_W-1:0]    out_right_px,
  output logic [COORD_W-1:0]    out_bottom_px,
  output logic [1:0]            out_verdict
);

  // Configuration
  logic [COORD_W-1:0] frame_w_r, frame_h_r, ratio_lo_r, ratio_hi_r;
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r  <= RST_FRAME_WIDTH;
      frame_h_r  <= RST_FRAME_HEIGHT;
      scale_r    <= RST_BALL_SCALE;
      ratio_lo_r <= RST_BALL_RATIO_LOW;
      ratio_hi_r <= RST_BALL_RATIO_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:     frame_w_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT:    frame_h_r  <= cfg_wdata;
        CFG_BALL_SCALE:      scale_r    <= cfg_wdata[SCALE_W-1:0];
        CFG_BALL_RATIO_LOW:  ratio_lo_r <= cfg_wdata;
        CFG_BALL_RATIO_HIGH: ratio_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Captured request
  logic [7:0]        label_r;
  logic [FRAC_W-1:0] conf_r, cx_r, cy_r, bwr_r, bhr_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      label_r <= in_class_label;
      conf_r  <= in_confidence;
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      bwr_r   <= in_box_w;
      bhr_r   <= in_box_h;
    end
  end

  // Corner operands: 2c - s (floored at 0) and 2c + s
  logic [FRAC_W:0]   twice_x, twice_y, diff_x, diff_y;
  logic [FRAC_W+1:0] sum_x, sum_y;
  logic              pos_x, pos_y;

  assign twice_x = {cx_r, 1'b0};
  assign twice_y = {cy_r, 1'b0};
  assign pos_x   = twice_x > {1'b0, bwr_r};
  assign pos_y   = twice_y > {1'b0, bhr_r};
  assign diff_x  = twice_x - {1'b0, bwr_r};
  assign diff_y  = twice_y - {1'b0, bhr_r};
  assign sum_x   = {1'b0, twice_x} + {2'b00, bwr_r};
  assign sum_y   = {1'b0, twice_y} + {2'b00, bhr_r};

  // Box size and scale products
  logic [COORD_W-1:0] bw_r, bh_r;
  logic [20:0]        fw_scale_r, fh_scale_r;

  // Two shared multipliers, x side and y side (low and high ratio in the final step)
  logic [17:0] mx_a, my_a;
  logic [11:0] mx_b, my_b;
  logic [29:0] mx_p, my_p;

  always_comb begin
    mx_a = pos_x ? {1'b0, diff_x} : '0;
    my_a = pos_y ? {1'b0, diff_y} : '0;
    mx_b = frame_w_r;
    my_b = frame_h_r;
    if (cmd.step_hi) begin
      mx_a = sum_x;
      my_a = sum_y;
    end else if (cmd.step_dim) begin
      mx_a = {9'd0, scale_r};
      my_a = {9'd0, scale_r};
    end else if (cmd.step_fin) begin
      mx_a = {6'd0, bh_r};
      my_a = {6'd0, bh_r};
      mx_b = ratio_lo_r;
      my_b = ratio_hi_r;
    end
  end

  assign mx_p = mx_a * mx_b;
  assign my_p = my_a * my_b;

  // High corner clamp at size-1, or 0 for a zero size
  logic [COORD_W-1:0] lim_x, lim_y, hi_x, hi_y;
  logic [COORD_W:0]   raw_x, raw_y;

  assign lim_x = (frame_w_r == '0) ? '0 : frame_w_r - 1'b1;
  assign lim_y = (frame_h_r == '0) ? '0 : frame_h_r - 1'b1;
  assign raw_x = mx_p[29:17];
  assign raw_y = my_p[29:17];
  assign hi_x  = (raw_x > {1'b0, lim_x}) ? lim_x : raw_x[COORD_W-1:0];
  assign hi_y  = (raw_y > {1'b0, lim_y}) ? lim_y : raw_y[COORD_W-1:0];

  logic [COORD_W-1:0] left_r, top_r, right_r, bottom_r;

  always_ff @(posedge clk) begin
    if (cmd.step_lo) begin
      left_r <= mx_p[28:17];
      top_r  <= my_p[28:17];
    end
    if (cmd.step_hi) begin
      right_r  <= hi_x;
      bottom_r <= hi_y;
    end
    if (cmd.step_dim) begin
      // clamping keeps right >= left and bottom >= top
      bw_r       <= right_r - left_r;
      bh_r       <= bottom_r - top_r;
      fw_scale_r <= mx_p[20:0];
      fh_scale_r <= my_p[20:0];
    end
  end

  // Verdict
  logic [FRAC_W-1:0] best_ball_r, best_goal_r, best_obst_r;
  logic [19:0]       bw256, bh256;
  logic              ball_ok, goal_ok, obst_ok;
  logic [1:0]        verdict;

  assign bw256 = {bw_r, 8'd0};
  assign bh256 = {bh_r, 8'd0};

  assign ball_ok = (conf_r > best_ball_r)
                && ({1'b0, bw256} < fw_scale_r)
                && ({1'b0, bh256} < fh_scale_r)
                && (bw_r != '0) && (bh_r != '0)
                && ({4'd0, bw256} > mx_p[23:0])
                && ({4'd0, bw256} < my_p[23:0]);
  assign goal_ok = conf_r > best_goal_r;
  assign obst_ok = (conf_r > best_obst_r)
                && ({bw_r, 1'b0} < {1'b0, frame_w_r})
                && ({bh_r, 1'b0} < {1'b0, frame_h_r});

  always_comb begin
    verdict = VERDICT_REJECT;
    case (label_r)
      LABEL_BALL:     if (ball_ok) verdict = VERDICT_BALL;
      LABEL_GOAL:     if (goal_ok) verdict = VERDICT_GOAL;
      LABEL_OBSTACLE: if (obst_ok) verdict = VERDICT_OBSTACLE;
      default:        verdict = VERDICT_REJECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_ball_r <= '0;
      best_goal_r <= '0;
      best_obst_r <= '0;
    end else if (cmd.load && in_first_in_frame) begin
      best_ball_r <= '0;
      best_goal_r <= '0;
      best_obst_r <= '0;
    end else if (cmd.step_fin) begin
      if (verdict == VERDICT_BALL)     best_ball_r <= conf_r;
      if (verdict == VERDICT_GOAL)     best_goal_r <= conf_r;
      if (verdict == VERDICT_OBSTACLE) best_obst_r <= conf_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.step_fin) begin
      out_left_px   <= left_r;
      out_top_px    <= top_r;
      out_right_px  <= right_r;
      out_bottom_px <= bottom_r;
      out_verdict   <= verdict;
    end
  end

endmodule

// ===== hdl/detection_box_class_filter_unit.sv =====
// Top level of the detection box class filter: sequencer plus datapath.
// Depends on dbcf_pkg, dbcf_ctrl, dbcf_dp and the assertion macro header.
//
//   channel | handshake           | payload
//   in      | in_valid/in_ready   | first_in_frame, class_label, confidence,
//           |                     | center_x, center_y, box_w, box_h
//   out     | out_valid/out_ready | left_px, top_px, right_px, bottom_px, verdict
//   cfg     | cfg_we              | cfg_index, cfg_wdata (write only)
//
// A box passes through the accept step and four sequencer steps using two
// shared 18x12 multipliers (low corners, high corners, size, ratio and verdict).
// The result register lets the next box be accepted while a result waits.
// The final step holds while the result register is full and not being taken.
// Reset loads the register defaults and clears the three class maxima.
`timescale 1ns / 1ps
`include "detection_box_class_filter_unit_macros.svh"

module detection_box_class_filter_unit
  import dbcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_first_in_frame,
  input  logic [7:0]            in_class_label,
  input  logic [FRAC_W-1:0]     in_confidence,
  input  logic [FRAC_W-1:0]     in_center_x,
  input  logic [FRAC_W-1:0]     in_center_y,
  input  logic [FRAC_W-1:0]     in_box_w,
  input  logic [FRAC_W-1:0]     in_box_h,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    out_left_px,
  output logic [COORD_W-1:0]    out_top_px,
  output logic [COORD_W-1:0]    out_right_px,
  output logic [COORD_W-1:0]    out_bottom_px,
  output logic [1:0]            out_verdict
);

  dbcf_cmd_t  cmd;
  logic [4:0] cmd_vec;

  assign cmd_vec = cmd;

  dbcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dbcf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_first_in_frame (in_first_in_frame),
    .in_class_label    (in_class_label),
    .in_confidence     (in_confidence),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_box_w          (in_box_w),
    .in_box_h          (in_box_h),
    .out_left_px       (out_left_px),
    .out_top_px        (out_top_px),
    .out_right_px      (out_right_px),
    .out_bottom_px     (out_bottom_px),
    .out_verdict       (out_verdict)
  );

  `DBCF_ASSERT_NEXT(a_busy_after_load, cmd.load, !in_ready, "accepted while busy")
  `DBCF_ASSERT_NEXT(a_fin_shows_result, cmd.step_fin, out_valid, "result not shown")
  `DBCF_ASSERT_SAME(a_one_step, 1'b1, $onehot0(cmd_vec), "overlapping steps")
  `DBCF_ASSERT_SAME(a_corner_order, out_valid, (out_right_px >= out_left_px) && (out_bottom_px >= out_top_px), "corners out of order")

endmodule
